FILE: hdl/aspool_pkg.sv
`default_nettype none
package aspool_pkg;

  // Sizing
  localparam int unsigned POOL_DEPTH  = 1024;
  localparam int unsigned MAX_WORKERS = 16;

  localparam int unsigned ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned MAP_W  = MAX_WORKERS;
  localparam int unsigned CNT_W  = $clog2(MAX_WORKERS + 1);
  localparam int unsigned NIDX_W = (MAP_W > 1) ? $clog2(MAP_W) : 1;

  // Field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned WID_W      = 5;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned POOL_W     = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Config reset values
  localparam logic [WID_W-1:0]  WORKER_COUNT_RST = WID_W'(7);
  localparam logic [WID_W-1:0]  ROOT_RANK_RST    = WID_W'(0);
  localparam logic [POOL_W-1:0] POOL_SIZE_RST    = POOL_W'(1024);

  typedef enum logic [CMD_W-1:0] {
    CMD_DATA     = 2'd0,
    CMD_ROOT_ACK = 2'd1,
    CMD_RETX     = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK  = 2'd0,
    KIND_NAK  = 2'd1,
    KIND_ROOT = 2'd2,
    KIND_REL  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORKER_COUNT = 2'd0,
    CFG_ROOT_RANK    = 2'd1,
    CFG_POOL_SIZE    = 2'd2
  } cfg_idx_e;

  // Per-slot record kept in the slot RAM
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [MAP_W-1:0] map;
    logic [CNT_W-1:0] cnt;
    logic             sent;
  } slot_rec_t;

  localparam int unsigned REC_W = $bits(slot_rec_t);

  // One outgoing message
  typedef struct packed {
    kind_e             kind;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] slot;
    logic [WID_W-1:0]  dest;
    logic              arm;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/aspool_ifs.sv
`default_nettype none
interface aspool_in_if;
  logic                          valid;
  logic                          ready;
  logic [aspool_pkg::CMD_W-1:0]  command;
  logic [aspool_pkg::SEQ_W-1:0]  seq_num;
  logic [aspool_pkg::SLOT_W-1:0] slot;
  logic [aspool_pkg::WID_W-1:0]  worker;

  modport source (output valid, output command, output seq_num, output slot,
                  output worker, input ready);
  modport sink   (input valid, input command, input seq_num, input slot,
                  input worker, output ready);
endinterface

interface aspool_out_if;
  logic                          valid;
  logic                          ready;
  logic [aspool_pkg::KIND_W-1:0] kind;
  logic [aspool_pkg::SEQ_W-1:0]  out_seq;
  logic [aspool_pkg::SLOT_W-1:0] out_slot;
  logic [aspool_pkg::WID_W-1:0]  dest_worker;
  logic                          arm_timer;
  logic                          last;

  modport source (output valid, output kind, output out_seq, output out_slot,
                  output dest_worker, output arm_timer, output last, input ready);
  modport sink   (input valid, input kind, input out_seq, input out_slot,
                  input dest_worker, input arm_timer, input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/aspool_ram.sv
`default_nettype none
module aspool_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/aggregation_slot_pool_core.sv
// Flow: a taken request is registered along with its slot RAM read, then evaluated in ST_EVAL,
//   which may write back the slot and load the output register; no request is taken until idle.
//   Data that completes a slot adds an ST_ROOT step for the root message, and a NAK run scans
//   one worker ID per cycle while the output has room, up to the effective worker count.
// Reset: config registers return to their defaults at once; a clearing pass then
//   initializes all 1024 slots, one per cycle, with in_i.ready low (config writes still taken).
`default_nettype none
module aggregation_slot_pool_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  aspool_in_if.sink                             in_i,
  aspool_out_if.source                          out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [aspool_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [aspool_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import aspool_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,  // post-reset slot initialization sweep
    ST_IDLE,   // waiting for a request
    ST_EVAL,   // slot record is on the RAM read port
    ST_ROOT,   // send completed result after the ack
    ST_NAK     // walk worker IDs, one per cycle unless the output stalls
  } state_e;

  // Config registers
  logic [WID_W-1:0]  wc_q, root_q;
  logic [POOL_W-1:0] pool_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q   <= WORKER_COUNT_RST;
      root_q <= ROOT_RANK_RST;
      pool_q <= POOL_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WORKER_COUNT: wc_q   <= cfg_data_i[WID_W-1:0];
        CFG_ROOT_RANK:    root_q <= cfg_data_i[WID_W-1:0];
        CFG_POOL_SIZE:    pool_q <= cfg_data_i[POOL_W-1:0];
        default:          ;  // unmapped index: dropped
      endcase
    end
  end

  // Sequencer state and registers
  state_e             state_q, state_d, nxt;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [MAP_W-1:0]   nak_q, nak_d, nak_nxt, nak_clr;
  logic [NIDX_W-1:0]  nidx_q, nidx_d, nidx_nxt;
  logic               ovalid_q;
  res_t               ores_q;

  // Request holding registers (payload)
  logic [CMD_W-1:0]   cmd_q;
  logic [SEQ_W-1:0]   seq_q, cur_q, cur_d;
  logic [SLOT_W-1:0]  slot_q;
  logic [WID_W-1:0]   wrk_q;

  // Slot RAM
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  slot_rec_t          ram_wdata, wrec, rec;
  logic [REC_W-1:0]   ram_rdata;

  aspool_ram #(
    .WIDTH (REC_W),
    .DEPTH (POOL_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rec = slot_rec_t'(ram_rdata);

  // Effective worker count and its bitmap mask
  logic [CNT_W-1:0] n_eff;
  logic [MAP_W-1:0] wmask, wbit;
  assign n_eff = (32'(wc_q) > MAX_WORKERS) ? CNT_W'(MAX_WORKERS) : CNT_W'(wc_q);

  always_comb begin
    for (int i = 0; i < MAP_W; i++) begin
      wmask[i] = (32'(i) < 32'(n_eff));
    end
  end

  // Request filtering at accept time
  logic in_ready, accept, slot_ok, req_ok;
  assign in_ready = (state_q == ST_IDLE);
  assign accept   = in_i.valid && in_ready;
  assign slot_ok  = (32'(in_i.slot) < 32'(pool_q)) && (32'(in_i.slot) < POOL_DEPTH);

  always_comb begin
    case (cmd_e'(in_i.command))
      CMD_DATA:     req_ok = (in_i.worker != '0) && (32'(in_i.worker) <= 32'(n_eff));
      CMD_ROOT_ACK: req_ok = 1'b1;
      CMD_RETX:     req_ok = 1'b1;
      default:      req_ok = 1'b0;  // unused command
    endcase
  end

  assign in_i.ready = in_ready;
  assign ram_re     = accept;
  assign ram_raddr  = ADDR_W'(in_i.slot);

  // Evaluation helpers
  logic             can_emit, emit_want, we_want, stall, emit;
  logic             complete, is_new, done_now;
  logic [CNT_W-1:0] new_cnt;
  res_t             res;

  assign can_emit = !ovalid_q || out_o.ready;
  assign wbit     = MAP_W'(1) << (wrk_q - WID_W'(1));
  assign complete = (rec.cnt == n_eff);
  assign is_new   = ((rec.map & wbit) == '0);
  assign new_cnt  = rec.cnt + CNT_W'(1);
  assign done_now = is_new && (new_cnt == n_eff);
  assign nak_clr  = nak_q & ~(MAP_W'(1) << nidx_q);

  always_comb begin
    nxt       = state_q;
    clr_d     = clr_q;
    nak_nxt   = nak_q;
    nidx_nxt  = nidx_q;
    cur_d     = cur_q;
    emit_want = 1'b0;
    we_want   = 1'b0;
    ram_waddr = ADDR_W'(slot_q);
    wrec      = rec;
    res.kind  = KIND_ACK;
    res.seq   = seq_q;
    res.slot  = slot_q;
    res.dest  = wrk_q;
    res.arm   = 1'b0;
    res.last  = 1'b1;

    case (state_q)
      ST_CLEAR: begin
        we_want   = 1'b1;
        ram_waddr = clr_q;
        wrec      = '{seq: SEQ_W'(clr_q), map: '0, cnt: '0, sent: 1'b0};
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(POOL_DEPTH - 1)) begin
          nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept && slot_ok && req_ok) begin
          nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        cur_d = rec.seq;
        nxt   = ST_IDLE;
        case (cmd_e'(cmd_q))
          CMD_DATA: begin
            if (seq_q < rec.seq) begin
              emit_want = 1'b1;  // old sequence: plain ack
            end else if (seq_q == rec.seq) begin
              emit_want = 1'b1;
              res.last  = !done_now;
              if (is_new) begin
                we_want   = 1'b1;
                wrec.map  = rec.map | wbit;
                wrec.cnt  = new_cnt;
                wrec.sent = rec.sent | done_now;
              end
              if (done_now) begin
                nxt = ST_ROOT;
              end
            end else if (complete) begin
              // Ahead of the slot: forward once if not yet sent
              if (!rec.sent) begin
                emit_want = 1'b1;
                we_want   = 1'b1;
                wrec.sent = 1'b1;
                res.kind  = KIND_ROOT;
                res.seq   = rec.seq;
                res.dest  = root_q;
                res.arm   = 1'b1;
              end
            end else begin
              // NAK every missing worker
              nak_nxt  = ~rec.map & wmask;
              nidx_nxt = '0;
              if ((~rec.map & wmask) != '0) begin
                nxt = ST_NAK;
              end
            end
          end

          CMD_ROOT_ACK: begin
            if ((wrk_q == root_q) && (seq_q == rec.seq)) begin
              emit_want = 1'b1;
              we_want   = 1'b1;
              wrec      = '{seq: rec.seq + SEQ_W'(pool_q), map: '0, cnt: '0, sent: 1'b0};
              res.kind  = KIND_REL;
              res.seq   = rec.seq;
              res.dest  = root_q;
            end
          end

          CMD_RETX: begin
            if (complete && rec.sent) begin
              emit_want = 1'b1;
              res.kind  = KIND_ROOT;
              res.seq   = rec.seq;
              res.dest  = root_q;
              res.arm   = 1'b1;
            end
          end

          default: ;
        endcase
      end

      ST_ROOT: begin
        emit_want = 1'b1;
        res.kind  = KIND_ROOT;
        res.seq   = cur_q;
        res.dest  = root_q;
        res.arm   = 1'b1;
        nxt       = ST_IDLE;
      end

      ST_NAK: begin
        nidx_nxt = nidx_q + NIDX_W'(1);
        if (nak_q[nidx_q]) begin
          emit_want = 1'b1;
          nak_nxt   = nak_clr;
          res.kind  = KIND_NAK;
          res.seq   = cur_q;
          res.dest  = WID_W'(nidx_q) + WID_W'(1);
          res.last  = (nak_clr == '0);
          if (nak_clr == '0) begin
            nxt = ST_IDLE;
          end
        end
      end

      default: nxt = ST_IDLE;
    endcase

    // Hold the sequencer and the RAM write while a result waits on a full output register
    stall     = emit_want && !can_emit;
    emit      = emit_want && !stall;
    ram_we    = we_want && !stall;
    state_d   = stall ? state_q : nxt;
    nak_d     = stall ? nak_q : nak_nxt;
    nidx_d    = stall ? nidx_q : nidx_nxt;
  end

  assign ram_wdata = wrec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      nak_q    <= '0;
      nidx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nak_q   <= nak_d;
      nidx_q  <= nidx_d;
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_i.command;
      seq_q  <= in_i.seq_num;
      slot_q <= in_i.slot;
      wrk_q  <= in_i.worker;
    end
    cur_q <= cur_d;
    if (emit) begin
      ores_q <= res;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.kind        = ores_q.kind;
  assign out_o.out_seq     = ores_q.seq;
  assign out_o.out_slot    = ores_q.slot;
  assign out_o.dest_worker = ores_q.dest;
  assign out_o.arm_timer   = ores_q.arm;
  assign out_o.last        = ores_q.last;

`ifndef SYNTH
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EVAL) || (state_q == ST_IDLE))
    else $error("request taken but sequencer did not go to evaluate or idle");

  a_nak_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NAK) |-> (nak_q != '0))
    else $error("NAK walk running with no missing worker left");

  a_arm_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (ores_q.arm == (ores_q.kind == KIND_ROOT)))
    else $error("arm_timer does not match a root message");

  a_ram_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR) || (state_q == ST_EVAL))
    else $error("slot RAM written outside clear or evaluate");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!ovalid_q || out_o.ready))
    else $error("result loaded over an untaken result");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_aggregation_slot_pool_core.sv
module tb_aggregation_slot_pool_core;
  timeunit 1ns;
  timeprecision 1ps;

  import aspool_pkg::*;

  // Command value with no meaning; the block must swallow it silently.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Wait after the last result before touching config or ending: covers the
  // result path plus a full 16-worker NAK scan, with margin.
  localparam int unsigned SETTLE_CYCLES = 24;
  // Printed mismatch lines are capped, counting goes on.
  localparam int unsigned MAX_PRINTED = 50;

  // One request as the driver presents it.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] slot;
    logic [WID_W-1:0]  wid;
  } req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  aspool_in_if  req_if ();
  aspool_out_if msg_if ();

  aggregation_slot_pool_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (msg_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 0;
  end

  // ---------------------------------------------------------------------------
  // Slot pool mirror: per-slot state and the config registers as the block
  // should hold them. Updated when a request is taken or a register written.
  // ---------------------------------------------------------------------------
  logic [SEQ_W-1:0]  seq_tbl  [POOL_DEPTH];
  logic [MAP_W-1:0]  map_tbl  [POOL_DEPTH];
  int unsigned       cnt_tbl  [POOL_DEPTH];
  bit                sent_tbl [POOL_DEPTH];
  logic [WID_W-1:0]  m_workers;
  logic [WID_W-1:0]  m_root;
  logic [POOL_W-1:0] m_pool;

  // Sequence number the stimulus side believes each slot expects; resynced
  // from the mirror at every config change (the pool is idle then).
  logic [SEQ_W-1:0]  gen_seq  [POOL_DEPTH];

  req_t        req_q [$];          // requests waiting for the driver
  res_t        expected_msgs [$];  // messages the block still owes us
  req_t        cur_req;            // request currently on the input channel
  res_t        held_msg;           // newest predicted message, last bit pending
  bit          held_valid;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          idle_on = 1'b1;
  int unsigned err_cnt = 0;
  int unsigned live_items;

  task automatic report_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Worker count actually in force: clamped to the bitmap width.
  function automatic int unsigned eff_workers();
    return (m_workers < MAX_WORKERS) ? int'(m_workers) : MAX_WORKERS;
  endfunction

  // Slots at or above this index are dropped.
  function automatic int unsigned slot_limit();
    return (m_pool < POOL_DEPTH) ? int'(m_pool) : POOL_DEPTH;
  endfunction

  // Messages are held back by one so the final one of a request can get
  // its last flag before it joins the expected queue.
  function automatic void emit_msg(kind_e k, logic [SEQ_W-1:0] s,
                                   logic [SLOT_W-1:0] sl, logic [WID_W-1:0] d);
    if (held_valid) expected_msgs = {expected_msgs, held_msg};
    held_msg.kind = k;
    held_msg.seq  = s;
    held_msg.slot = sl;
    held_msg.dest = d;
    held_msg.arm  = (k == KIND_ROOT);
    held_msg.last = 1'b0;
    held_valid    = 1'b1;
  endfunction

  // Apply one taken request to the mirror and queue the messages it causes.
  function automatic void predict_slot_update(input req_t r);
    int unsigned      eff;
    int unsigned      idx;
    int unsigned      id;
    logic [SEQ_W-1:0] cur;
    eff        = eff_workers();
    idx        = r.slot;
    held_valid = 1'b0;
    if (idx < slot_limit()) begin
      cur = seq_tbl[idx];
      case (r.cmd)
        CMD_DATA: begin
          if (r.wid != 0 && r.wid <= eff) begin
            if (r.seq < cur) begin
              // old sequence: just acknowledge
              emit_msg(KIND_ACK, r.seq, r.slot, r.wid);
            end else if (r.seq == cur) begin
              emit_msg(KIND_ACK, r.seq, r.slot, r.wid);
              if (!map_tbl[idx][r.wid-1]) begin
                map_tbl[idx][r.wid-1] = 1'b1;
                cnt_tbl[idx]++;
                if (cnt_tbl[idx] == eff) begin
                  emit_msg(KIND_ROOT, cur, r.slot, m_root);
                  sent_tbl[idx] = 1'b1;
                end
              end
            end else if (cnt_tbl[idx] == eff) begin
              // newer sequence on a complete slot: forward once, else quiet
              if (!sent_tbl[idx]) begin
                emit_msg(KIND_ROOT, cur, r.slot, m_root);
                sent_tbl[idx] = 1'b1;
              end
            end else begin
              // newer sequence on an incomplete slot: chase missing workers
              for (id = 1; id <= eff; id++)
                if (!map_tbl[idx][id-1]) emit_msg(KIND_NAK, cur, r.slot, WID_W'(id));
            end
          end
        end
        CMD_ROOT_ACK: begin
          if (r.wid == m_root && r.seq == cur) begin
            seq_tbl[idx]  = cur + SEQ_W'(m_pool);
            map_tbl[idx]  = '0;
            cnt_tbl[idx]  = 0;
            sent_tbl[idx] = 1'b0;
            emit_msg(KIND_REL, cur, r.slot, m_root);
          end
        end
        CMD_RETX: begin
          if (cnt_tbl[idx] == eff && sent_tbl[idx])
            emit_msg(KIND_ROOT, cur, r.slot, m_root);
        end
        default: ;
      endcase
    end
    if (held_valid) begin
      held_msg.last = 1'b1;
      expected_msgs = {expected_msgs, held_msg};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: pops the queue, holds valid until ready, and inserts
  // idle gaps after some requests.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      // request taken this edge: predict against the mirror right away
      if (req_if.valid && req_if.ready) predict_slot_update(cur_req);
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          req_if.valid   <= 1'b1;
          req_if.command <= cur_req.cmd;
          req_if.seq_num <= cur_req.seq;
          req_if.slot    <= cur_req.slot;
          req_if.worker  <= cur_req.wid;
          if (idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 16);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Message monitor: checks every taken message against the oldest
  // prediction and applies random backpressure bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      msg_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (msg_if.valid && msg_if.ready) begin
        if (expected_msgs.size() == 0) begin
          report_error($sformatf("unexpected message kind %0d slot %0d seq %0h dest %0d",
                                 msg_if.kind, msg_if.out_slot, msg_if.out_seq,
                                 msg_if.dest_worker));
        end else begin
          want = expected_msgs.pop_front();
          if (msg_if.kind !== want.kind || msg_if.out_seq !== want.seq ||
              msg_if.out_slot !== want.slot || msg_if.dest_worker !== want.dest ||
              msg_if.arm_timer !== want.arm || msg_if.last !== want.last)
            report_error($sformatf(
              "got kind %0d seq %0h slot %0d dest %0d arm %0b last %0b, want %0d %0h %0d %0d %0b %0b",
              msg_if.kind, msg_if.out_seq, msg_if.out_slot, msg_if.dest_worker,
              msg_if.arm_timer, msg_if.last,
              want.kind, want.seq, want.slot, want.dest, want.arm, want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        msg_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        msg_if.ready <= 1'b0;
      end else begin
        msg_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                           input logic [SLOT_W-1:0] slot, input logic [WID_W-1:0] wid);
    req_t r;
    r.cmd  = cmd;
    r.seq  = seq;
    r.slot = slot;
    r.wid  = wid;
    req_q = {req_q, r};
    live_items++;
  endtask

  // Requests the block should drop, plus fully random ones; not counted.
  task automatic queue_noise();
    int unsigned lim;
    int unsigned eff;
    req_t        r;
    lim    = slot_limit();
    eff    = eff_workers();
    r.cmd  = CMD_DATA;
    r.seq  = $urandom;
    r.slot = SLOT_W'($urandom);
    r.wid  = WID_W'($urandom);
    case ($urandom_range(0, 3))
      0: r.cmd = CMD_UNUSED;
      1: begin
        // worker ID 0 or beyond the active worker count
        r.wid  = ($urandom_range(0, 1) == 0) ? '0 : WID_W'($urandom_range(eff + 1, 31));
        r.slot = (lim > 0) ? SLOT_W'($urandom_range(0, lim - 1)) : '0;
      end
      2: begin
        if (lim < POOL_DEPTH) r.slot = SLOT_W'($urandom_range(lim, POOL_DEPTH - 1));
        r.cmd = CMD_W'($urandom_range(0, 2));
      end
      default: r.cmd = CMD_W'($urandom);
    endcase
    req_q = {req_q, r};
  endtask

  function automatic logic [SEQ_W-1:0] newer_seq(input logic [SEQ_W-1:0] s);
    if ($urandom_range(0, 3) == 0) return s + 1 + ($urandom >> 1);
    return s + 1 + $urandom_range(0, 4000);
  endfunction

  // One aggregation round on a slot: workers arrive in shuffled order with
  // duplicates, stale and early packets, retransmit ticks, then usually the
  // root releases the slot. Some rounds stop short and leave it partial.
  task automatic gen_round();
    int unsigned      lim;
    int unsigned      eff;
    int unsigned      sl;
    int unsigned      style;
    int unsigned      n_arrive;
    int unsigned      i;
    int unsigned      j;
    int unsigned      tmp;
    int unsigned      ids [MAX_WORKERS];
    logic [SEQ_W-1:0] s;
    lim = slot_limit();
    eff = eff_workers();
    // mostly a few hot slots so rounds revisit them
    if ($urandom_range(0, 3) != 0) sl = $urandom_range(0, ((lim < 6) ? lim : 6) - 1);
    else sl = $urandom_range(0, lim - 1);
    s = gen_seq[sl];
    for (i = 0; i < eff; i++) ids[i] = i + 1;
    for (i = eff; i > 1; i--) begin
      j          = $urandom_range(0, i - 1);
      tmp        = ids[i-1];
      ids[i-1]   = ids[j];
      ids[j]     = tmp;
    end
    style    = $urandom_range(0, 9);
    n_arrive = (style < 7) ? eff : $urandom_range(0, eff);
    for (i = 0; i < n_arrive; i++) begin
      queue_req(CMD_DATA, s, SLOT_W'(sl), WID_W'(ids[i]));
      case ($urandom_range(0, 11))
        0: queue_req(CMD_DATA, s, SLOT_W'(sl), WID_W'(ids[$urandom_range(0, i)]));
        1: if (s != 0) queue_req(CMD_DATA, s - $urandom_range(1, s), SLOT_W'(sl),
                                 WID_W'(ids[i]));
        2: queue_req(CMD_DATA, newer_seq(s), SLOT_W'(sl),
                     WID_W'(ids[$urandom_range(0, eff - 1)]));
        3: queue_req(CMD_RETX, $urandom, SLOT_W'(sl), WID_W'($urandom));
        4: queue_noise();
        default: ;
      endcase
    end
    if ($urandom_range(0, 1) == 0)
      queue_req(CMD_RETX, $urandom, SLOT_W'(sl), WID_W'($urandom));
    if (eff > 0 && $urandom_range(0, 2) == 0)
      queue_req(CMD_DATA, newer_seq(s), SLOT_W'(sl), WID_W'($urandom_range(1, eff)));
    if (style < 8) begin
      // near misses first: wrong sender, then wrong sequence
      if ($urandom_range(0, 3) == 0) queue_req(CMD_ROOT_ACK, s, SLOT_W'(sl), m_root + 1'b1);
      if ($urandom_range(0, 3) == 0) queue_req(CMD_ROOT_ACK, s + 1, SLOT_W'(sl), m_root);
      queue_req(CMD_ROOT_ACK, s, SLOT_W'(sl), m_root);
      gen_seq[sl] = s + SEQ_W'(m_pool);
    end
  endtask

  task automatic fill_random(input int unsigned n_items);
    live_items = 0;
    while (live_items < n_items) begin
      if (slot_limit() == 0) begin
        // no slot in use: everything is dropped
        queue_noise();
        live_items++;
      end else begin
        gen_round();
        if ($urandom_range(0, 4) == 0) queue_noise();
      end
    end
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_WORKER_COUNT: m_workers = val[WID_W-1:0];
      CFG_ROOT_RANK:    m_root    = val[WID_W-1:0];
      CFG_POOL_SIZE:    m_pool    = val;
      default: ;
    endcase
  endtask

  // Only called with the pool drained. Unused upper data bits get junk.
  task automatic set_config(input logic [WID_W-1:0] wc, input logic [WID_W-1:0] root,
                            input logic [POOL_W-1:0] pool);
    logic [CFG_DATA_W-WID_W-1:0] pad;
    int unsigned                 k;
    pad = (CFG_DATA_W-WID_W)'($urandom);
    write_cfg(CFG_WORKER_COUNT, {pad, wc});
    pad = (CFG_DATA_W-WID_W)'($urandom);
    write_cfg(CFG_ROOT_RANK, {pad, root});
    write_cfg(CFG_POOL_SIZE, pool);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    for (k = 0; k < POOL_DEPTH; k++) gen_seq[k] = seq_tbl[k];
  endtask

  // Sender holds off until every request is taken and every message is back,
  // then gives a NAK scan with no result time to finish.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_q.size() != 0 || req_if.valid || expected_msgs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned k;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    req_if.valid   = 1'b0;
    req_if.command = '0;
    req_if.seq_num = '0;
    req_if.slot    = '0;
    req_if.worker  = '0;
    msg_if.ready   = 1'b0;
    m_workers      = WORKER_COUNT_RST;
    m_root         = ROOT_RANK_RST;
    m_pool         = POOL_SIZE_RST;
    for (k = 0; k < POOL_DEPTH; k++) begin
      seq_tbl[k]  = k;
      map_tbl[k]  = '0;
      cnt_tbl[k]  = 0;
      sent_tbl[k] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed pass at reset config (7 workers, root 0, full pool); the
    // driver simply waits out the clearing pass on ready.
    queue_req(CMD_DATA, 0, 0, 1);                // first arrival
    queue_req(CMD_DATA, 5, 0, 2);                // early packet: NAKs to 2..7
    for (k = 2; k <= 7; k++) queue_req(CMD_DATA, 0, 0, WID_W'(k));  // last one completes
    queue_req(CMD_DATA, 9, 0, 3);                // complete and sent: quiet
    queue_req(CMD_RETX, 0, 0, 0);                // retransmit to root
    queue_req(CMD_ROOT_ACK, 0, 0, 5);            // ack from a non-root worker
    queue_req(CMD_ROOT_ACK, 1, 0, ROOT_RANK_RST);  // ack with wrong sequence
    queue_req(CMD_ROOT_ACK, 0, 0, ROOT_RANK_RST);  // release, seq moves by pool
    queue_req(CMD_DATA, 3, 0, 4);                // now stale: ack only
    queue_req(CMD_DATA, 1, 1, 0);                // worker 0 dropped
    queue_req(CMD_DATA, 1, 1, 31);               // worker out of range
    queue_req(CMD_UNUSED, 1, 1, 1);              // unused command
    queue_req(CMD_DATA, '1, 1023, 7);            // max seq on last slot: NAK all
    queue_req(CMD_DATA, 1023, 1023, 7);
    for (k = 1; k <= 3; k++) queue_req(CMD_DATA, 2, 2, WID_W'(k));  // partial slot 2
    for (k = 1; k <= 4; k++) queue_req(CMD_DATA, 3, 3, WID_W'(k));  // partial slot 3
    wait_drained();

    // Shrink to 3 workers: slot 2 turns complete but unsent, slot 3 carries
    // a stale count above the new worker count.
    set_config(3, 3, 1024);
    queue_req(CMD_DATA, 100, 2, 1);              // forwards the complete slot
    queue_req(CMD_DATA, 100, 3, 2);              // NAK scan finds nobody missing
    fill_random(90);
    wait_drained();

    set_config(16, 16, 1);                       // widest bitmap, single slot
    fill_random(70);
    wait_drained();

    set_config(20, 5, 2047);                     // count clamps, pool above depth
    fill_random(90);
    wait_drained();

    set_config(1, 0, 8);
    fill_random(60);
    wait_drained();

    set_config(0, 1, 4);                         // no workers: data all dropped
    fill_random(15);
    wait_drained();

    set_config(5, 31, 0);                        // empty pool: everything dropped
    fill_random(10);
    wait_drained();

    // Final stretch runs at full rate on both sides.
    idle_on = 1'b0;
    set_config(7, 2, 300);
    fill_random(140);
    wait_drained();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #(15_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
